// ===== sv/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/sfpp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfpp_pkg
// shared types and constants of the sync framed packet parser
// ----------------------------------------------------------------------------
package sfpp_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;

	// parser phase, one-hot
	typedef enum logic [5:0] {
		PH_HUNT    = 6'b000001,
		PH_SYNC1   = 6'b000010,
		PH_ID      = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_CHECK   = 6'b100000
	} phase_t;

	// one result item
	typedef struct packed {
		logic              payload_valid;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] frame_length;
		logic              frame_done;
		logic              frame_ok;
		logic [BYTE_W-1:0] error_total;
	} res_t;

endpackage

// ===== sv/sfpp_core.sv =====
// ----------------------------------------------------------------------------
// sfpp_core
// frame state machine: one byte in, one result out, state updated on step
// ----------------------------------------------------------------------------
module sfpp_core import sfpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] sync_first,
	input  logic [BYTE_W-1:0] sync_second,
	output res_t              res
);

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] id_q, id_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] pos_q, pos_d;
	logic [BYTE_W-1:0] err_q, err_d;

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		id_d    = id_q;
		len_d   = len_q;
		pos_d   = pos_q;
		err_d   = err_q;
		res     = '0;
		case (phase_q)
			PH_SYNC1: begin
				if (rx_byte == sync_second) begin
					phase_d = PH_ID;
					sum_d   = '0;
				end else begin
					err_d   = err_q + 8'd1;
					phase_d = PH_HUNT;
				end
			end
			PH_ID: begin
				id_d    = rx_byte;
				sum_d   = sum_q + rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				sum_d   = sum_q + rx_byte;
				pos_d   = '0;
				phase_d = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = pos_q;
				sum_d = sum_q + rx_byte;
				pos_d = pos_q + 8'd1;
				// last payload byte once the count reaches the length
				if (pos_d >= len_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				res.frame_done = 1'b1;
				if (rx_byte == sum_q) begin
					res.frame_ok = 1'b1;
				end else begin
					err_d = err_q + 8'd1;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = (rx_byte == sync_first) ? PH_SYNC1 : PH_HUNT;
			end
		endcase
		res.frame_id     = id_d;
		res.frame_length = len_d;
		res.error_total  = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			err_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			id_q    <= id_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			err_q   <= err_d;
		end
	end

endmodule

// ===== sv/sync_framed_packet_parser.sv =====
// ----------------------------------------------------------------------------
// sync_framed_packet_parser
// byte-serial receiver for sync-framed packets with additive checksum
// ----------------------------------------------------------------------------
// an accepted byte goes into the input register, then the result register;
// a full result register holds its item while out_ready is low
// throughput: 1 item per cycle unless the output stalls; the parser state
//   update is one 8-bit add and compare between input and result registers
// reset: arst_n clears the parser state, error counter and both pipeline
//   valid flags; sync registers return to 0xaa and 0x55
module sync_framed_packet_parser import sfpp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 payload_valid,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic [BYTE_W-1:0]    payload_index,
	output logic [BYTE_W-1:0]    frame_id,
	output logic [BYTE_W-1:0]    frame_length,
	output logic                 frame_done,
	output logic                 frame_ok,
	output logic [BYTE_W-1:0]    error_total
);

	// sync byte registers
	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;

	// input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// result stage
	logic valid_s2;
	res_t res_s2;
	res_t res;

	logic adv_s2;   // result register can load this cycle
	logic step;     // item in stage 1 moves to the result register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register is free when empty or being drained
	assign adv_s2   = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv_s2;
	// input register is free when empty or its item moves on
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state machine, updated once per item
	sfpp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_id      = res_s2.frame_id;
	assign frame_length  = res_s2.frame_length;
	assign frame_done    = res_s2.frame_done;
	assign frame_ok      = res_s2.frame_ok;
	assign error_total   = res_s2.error_total;

endmodule

// ===== sv/sfpp_checker.sv =====
// ----------------------------------------------------------------------------
// sfpp_checker
// port-level checks on the sync framed packet parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfpp_checker import sfpp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              payload_valid,
	input logic [BYTE_W-1:0] payload_byte,
	input logic [BYTE_W-1:0] payload_index,
	input logic              frame_done,
	input logic              frame_ok,
	input logic [BYTE_W-1:0] error_total
);

	// a byte is either payload or checksum, never both
	`ASSERT_IMPLY(a_kind_excl, clk, arst_n, out_valid, !(payload_valid && frame_done))
	// ok only reported on the checksum byte
	`ASSERT_IMPLY(a_ok_done, clk, arst_n, out_valid && frame_ok, frame_done)
	// non-payload items carry zeroed payload fields
	`ASSERT_IMPLY(a_pay_zero, clk, arst_n, out_valid && !payload_valid,
		(payload_byte == '0) && (payload_index == '0))
	// input only stalls behind a full, stalled result register
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)
	// stalled result holds its error count
	`ASSERT_NEXT(a_err_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(error_total))

endmodule

bind sync_framed_packet_parser sfpp_checker u_sfpp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.payload_valid (payload_valid),
	.payload_byte  (payload_byte),
	.payload_index (payload_index),
	.frame_done    (frame_done),
	.frame_ok      (frame_ok),
	.error_total   (error_total)
);
